[sv/omrt_pkg.sv]
package omrt_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_FIND    = 2'd1;
  localparam logic [1:0] OP_EXTRACT = 2'd2;

  localparam logic [2:0] KIND_ID     = 3'd0;
  localparam logic [2:0] KIND_PARENT = 3'd1;
  localparam logic [2:0] KIND_PRIO   = 3'd2;
  localparam logic [2:0] KIND_STATUS = 3'd3;
  localparam logic [2:0] KIND_ANY    = 3'd4;

  localparam logic [1:0] RES_OK   = 2'd0;
  localparam logic [1:0] RES_MISS = 2'd1;
  localparam logic [1:0] RES_FULL = 2'd2;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] parent;
    logic [15:0] prio;
    logic [7:0]  status;
  } record_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
  } query_t;

endpackage

[sv/omrt_cell.sv]
module omrt_cell
  import omrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cell_ctrl_t  ctrl,
  input  record_t     new_rec,
  input  record_t     next_rec,
  input  logic        next_valid,
  input  query_t      query,
  input  logic [31:0] prev_max,
  output record_t     rec,
  output logic        valid,
  output logic        match,
  output logic [31:0] run_max
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rec <= new_rec;
    end else if (ctrl.shift) begin
      rec <= next_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end
  end

  // The running maximum ripples one cell per cycle toward the tail.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_max <= 32'd0;
    end else if (valid && (rec.id > prev_max)) begin
      run_max <= rec.id;
    end else begin
      run_max <= prev_max;
    end
  end

  always_comb begin
    case (query.kind)
      KIND_ID:     match = valid && (rec.id == query.key);
      KIND_PARENT: match = valid && (rec.parent == query.key);
      KIND_PRIO:   match = valid && ({16'd0, rec.prio} == query.key);
      KIND_STATUS: match = valid && ({24'd0, rec.status} == query.key);
      KIND_ANY:    match = valid;
      default:     match = 1'b0;
    endcase
  end

endmodule

[sv/ordered_multikey_record_table_unit.sv]
// Channel  Handshake           Payload
// in       in_valid/in_stall   opcode, query_kind, key_value, new_id, new_parent,
//                              new_priority, new_status
// out      out_valid/out_stall result_code, hit_id, hit_parent, hit_priority,
//                              hit_status, entry_count, highest_id
//
// An insert, a find or an extract that misses loads its result in S_CMP, or in S_SEND
// while the output register is held. An extract that removes a record waits in S_MAX
// while the running maximum ripples along the chain to rebuild it, then loads in S_SEND.
// One item is in work at a time; a finished result waits in the output register.
// Reset clears the valid bits, the count and the control state at once.
// While out_stall is high one more item is still taken and computed.
module ordered_multikey_record_table_unit
  import omrt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [2:0]  query_kind,
  input  logic [31:0] key_value,
  input  logic [31:0] new_id,
  input  logic [31:0] new_parent,
  input  logic [15:0] new_priority,
  input  logic [7:0]  new_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_code,
  output logic [31:0] hit_id,
  output logic [31:0] hit_parent,
  output logic [15:0] hit_priority,
  output logic [7:0]  hit_status,
  output logic [4:0]  entry_count,
  output logic [31:0] highest_id
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_MAX  = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  typedef struct packed {
    logic [1:0]  code;
    record_t     rec;
    logic [31:0] highest;
  } res_t;

  state_t         state;
  logic [CW-1:0]  held_count;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  wait_cnt;
  logic [31:0]    highest;
  logic [1:0]     cmd_op;
  query_t         cmd_query;
  record_t        cmd_rec;
  res_t           res_now;
  res_t           res_q;

  record_t        cell_rec [DEPTH];
  logic [31:0]    cell_max [DEPTH];
  cell_ctrl_t     cell_ctrl [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] neg_match;
  logic [DEPTH-1:0] first_hit;
  logic [DEPTH-1:0] shift_mask;
  logic           any_hit;
  record_t        hit_rec;
  logic           table_full;
  logic           ins_ok;
  logic           ext_hit;
  logic           is_query;
  logic           out_free;
  logic           accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op    <= opcode;
      cmd_query <= '{kind: query_kind, key: key_value};
      cmd_rec   <= '{id: new_id, parent: new_parent, prio: new_priority,
                     status: new_status};
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].load  = (state == S_CMP) && ins_ok && (held_count == CW'(i));
    assign cell_ctrl[i].shift = (state == S_CMP) && ext_hit && shift_mask[i];

    if (i == DEPTH - 1) begin : g_tail
      omrt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (cell_ctrl[i]),
        .new_rec    (cmd_rec),
        .next_rec   (cell_rec[i]),
        .next_valid (1'b0),
        .query      (cmd_query),
        .prev_max   (cell_max[i-1]),
        .rec        (cell_rec[i]),
        .valid      (cell_valid[i]),
        .match      (cell_match[i]),
        .run_max    (cell_max[i])
      );
    end else if (i == 0) begin : g_head
      omrt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (cell_ctrl[i]),
        .new_rec    (cmd_rec),
        .next_rec   (cell_rec[i+1]),
        .next_valid (cell_valid[i+1]),
        .query      (cmd_query),
        .prev_max   (32'd0),
        .rec        (cell_rec[i]),
        .valid      (cell_valid[i]),
        .match      (cell_match[i]),
        .run_max    (cell_max[i])
      );
    end else begin : g_mid
      omrt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (cell_ctrl[i]),
        .new_rec    (cmd_rec),
        .next_rec   (cell_rec[i+1]),
        .next_valid (cell_valid[i+1]),
        .query      (cmd_query),
        .prev_max   (cell_max[i-1]),
        .rec        (cell_rec[i]),
        .valid      (cell_valid[i]),
        .match      (cell_match[i]),
        .run_max    (cell_max[i])
      );
    end
  end

  // Lowest set bit marks the oldest match; everything from it upward shifts down.
  assign neg_match  = ~cell_match + 1'b1;
  assign first_hit  = cell_match & neg_match;
  assign shift_mask = cell_match | neg_match;
  assign any_hit    = |cell_match;

  always_comb begin
    hit_rec = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_rec = hit_rec | (first_hit[i] ? cell_rec[i] : '0);
    end
  end

  assign table_full = (held_count == CW'(DEPTH));
  assign ins_ok     = (cmd_op == OP_INSERT) && !table_full;
  assign ext_hit    = (cmd_op == OP_EXTRACT) && any_hit;
  assign is_query   = (cmd_op == OP_FIND) || (cmd_op == OP_EXTRACT);

  always_comb begin
    res_now.code    = RES_MISS;
    res_now.rec     = '0;
    res_now.highest = highest;
    count_next      = held_count;
    if (cmd_op == OP_INSERT) begin
      res_now.code = table_full ? RES_FULL : RES_OK;
      if (ins_ok) begin
        count_next = held_count + 1'b1;
        if (cmd_rec.id > highest) begin
          res_now.highest = cmd_rec.id;
        end
      end
    end else if (is_query && any_hit) begin
      res_now.code = RES_OK;
      res_now.rec  = hit_rec;
      if (ext_hit) begin
        count_next = held_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      highest    <= 32'd0;
      wait_cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          held_count <= count_next;
          highest    <= res_now.highest;
          wait_cnt   <= '0;
          if (ext_hit) begin
            state <= S_MAX;
          end else if (out_free) begin
            state <= S_IDLE;
          end else begin
            state <= S_SEND;
          end
        end
        S_MAX: begin
          if (wait_cnt == CW'(DEPTH)) begin
            highest <= cell_max[DEPTH-1];
            state   <= S_SEND;
          end else begin
            wait_cnt <= wait_cnt + 1'b1;
          end
        end
        S_SEND: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CMP) begin
      res_q <= res_now;
    end else if ((state == S_MAX) && (wait_cnt == CW'(DEPTH))) begin
      res_q.highest <= cell_max[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (((state == S_CMP) && !ext_hit && out_free) ||
                 ((state == S_SEND) && out_free)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_CMP) && !ext_hit && out_free) begin
      result_code  <= res_now.code;
      hit_id       <= res_now.rec.id;
      hit_parent   <= res_now.rec.parent;
      hit_priority <= res_now.rec.prio;
      hit_status   <= res_now.rec.status;
      entry_count  <= 5'(count_next);
      highest_id   <= res_now.highest;
    end else if ((state == S_SEND) && out_free) begin
      result_code  <= res_q.code;
      hit_id       <= res_q.rec.id;
      hit_parent   <= res_q.rec.parent;
      hit_priority <= res_q.rec.prio;
      hit_status   <= res_q.rec.status;
      entry_count  <= 5'(held_count);
      highest_id   <= res_q.highest;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(DEPTH))
    else $error("record count exceeds table depth");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("valid cells are not packed at the head of the chain");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(held_count))
    else $error("valid cells disagree with the record count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) && ins_ok |=> held_count == CW'($past(held_count) + 1'b1))
    else $error("insert did not add one record");

  a_extract_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) && ext_hit |=> held_count == CW'($past(held_count) - 1'b1))
    else $error("extract did not remove one record");

endmodule
